>>> hdl/adjacent_line_dedup_defines.svh
// Assertion macros used by the checker of the line dedup block.
`ifndef ADJACENT_LINE_DEDUP_DEFINES_SVH
`define ADJACENT_LINE_DEDUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adjacent_line_dedup: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ADL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adjacent_line_dedup: assertion failed");

`endif

>>> hdl/adl_pkg.sv
`default_nettype none

package adl_pkg;

  // Line buffer geometry.
  localparam int MaxLine = 1024;
  localparam int AddrW   = $clog2(MaxLine);
  localparam int PosW    = $clog2(MaxLine + 1);

  // Character codes.
  localparam logic [7:0] NlByte  = 8'd10;
  localparam logic [7:0] UpA     = 8'd65;
  localparam logic [7:0] UpZ     = 8'd90;
  localparam logic [7:0] CaseGap = 8'd32;

  // Counter width and the record queue.
  localparam int CntW      = 32;
  localparam int FifoDepth = 8;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgDupOnly     = 2'd0,
    CfgSinglesOnly = 2'd1,
    CfgIgnoreCase  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic dup_only;
    logic singles_only;
    logic ignore_case;
  } cfg_t;

  // Per-byte information passed from the position stage to the run stage.
  typedef struct packed {
    logic       valid;
    logic       close;
    logic       last;
    logic       cmp;
    logic       len_miss;
    logic       len_eq;
    logic       too_long;
    logic [7:0] data;
  } s1_t;

  typedef struct packed {
    logic [CntW-1:0] first_line;
    logic [CntW-1:0] run_length;
    logic            overflow;
    logic            final_rec;
  } rec_t;

  // Up to two records pushed per byte, the first one first.
  typedef struct packed {
    logic push_a;
    rec_t rec_a;
    logic push_b;
    rec_t rec_b;
  } push_t;

  function automatic logic [7:0] fold_byte(logic [7:0] c, logic ic);
    logic [7:0] r;
    r = c;
    if (ic && (c inside {[UpA:UpZ]})) begin
      r = c + CaseGap;
    end
    return r;
  endfunction

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] v);
    logic [CntW-1:0] r;
    r = (v == '1) ? v : v + CntW'(1);
    return r;
  endfunction

  function automatic logic pass_filter(logic [CntW-1:0] len, cfg_t cfg);
    logic ok;
    ok = 1'b1;
    if (cfg.dup_only && (len == CntW'(1))) ok = 1'b0;
    if (cfg.singles_only && (len > CntW'(1))) ok = 1'b0;
    return ok;
  endfunction

endpackage

`default_nettype wire

>>> hdl/adl_line_ram.sv
`default_nettype none

// Single-port line buffer, read-first: a read and a write to the same entry in
// one cycle return the old byte, which is exactly the stored byte to compare.
module adl_line_ram
  import adl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [7:0]       wdata_i,
  output logic      [7:0]       rdata_o
);

  logic [7:0] mem_q [MaxLine];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem_q[addr_i];
      mem_q[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/adl_position.sv
`default_nettype none

// Front stage: tracks the write position in the current line and the length
// of the previous one, drives the line buffer and hands each byte on.
module adl_position
  import adl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       data_i,
  input  wire logic             last_i,
  output logic                  ram_en_o,
  output logic      [AddrW-1:0] ram_addr_o,
  output logic      [7:0]       ram_wdata_o,
  output s1_t                   s1_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] prev_len_q, prev_len_d;
  logic            too_long_q, too_long_d;
  s1_t             s1_q, s1_d;

  logic            take;
  logic            in_range;
  logic            stored;
  logic [PosW-1:0] pos_after;
  logic            ovf_now;
  logic            close;

  always_comb begin
    take      = (data_i != NlByte);
    in_range  = (pos_q < PosW'(MaxLine));
    stored    = take && in_range;
    pos_after = stored ? pos_q + PosW'(1) : pos_q;
    ovf_now   = too_long_q || (take && !in_range);
    close     = !take || last_i;

    ram_en_o    = accept_i && stored;
    ram_addr_o  = pos_q[AddrW-1:0];
    ram_wdata_o = data_i;

    pos_d      = pos_q;
    prev_len_d = prev_len_q;
    too_long_d = too_long_q;
    if (accept_i) begin
      if (close) begin
        // The closed line becomes the reference; end of input starts afresh.
        prev_len_d = last_i ? '0 : pos_after;
        pos_d      = '0;
        too_long_d = 1'b0;
      end else begin
        pos_d      = pos_after;
        too_long_d = ovf_now;
      end
    end

    s1_d.valid    = accept_i;
    s1_d.close    = close;
    s1_d.last     = last_i;
    s1_d.cmp      = stored && (pos_q < prev_len_q);
    s1_d.len_miss = stored && (pos_q >= prev_len_q);
    s1_d.len_eq   = (pos_after == prev_len_q);
    s1_d.too_long = ovf_now;
    s1_d.data     = data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      prev_len_q <= '0;
      too_long_q <= 1'b0;
      s1_q       <= '0;
    end else begin
      pos_q      <= pos_d;
      prev_len_q <= prev_len_d;
      too_long_q <= too_long_d;
      s1_q       <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

`default_nettype wire

>>> hdl/adl_run_tracker.sv
`default_nettype none

// Run stage: finishes the byte compare against the buffer read data, closes
// lines, counts runs of equal lines and forms the records.
module adl_run_tracker
  import adl_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire s1_t        s1_i,
  input  wire logic [7:0] rdata_i,
  output push_t           push_o
);

  logic            mismatch_q, mismatch_d;
  logic [CntW-1:0] run_count_q, run_count_d;
  logic [CntW-1:0] run_start_q, run_start_d;
  logic [CntW-1:0] line_num_q, line_num_d;
  logic            run_open_q, run_open_d;
  logic            run_ovf_q, run_ovf_d;

  logic            mis;
  logic            equal;
  logic [CntW-1:0] new_count;
  logic [CntW-1:0] new_start;
  logic            new_ovf;
  logic            emit_a;
  logic            emit_b;

  always_comb begin
    mis = mismatch_q || s1_i.len_miss ||
          (s1_i.cmp && (fold_byte(rdata_i, cfg_i.ignore_case) !=
                        fold_byte(s1_i.data, cfg_i.ignore_case)));
    equal     = run_open_q && !mis && s1_i.len_eq;
    new_count = equal ? sat_inc(run_count_q) : CntW'(1);
    new_start = equal ? run_start_q : line_num_q;
    new_ovf   = equal ? (run_ovf_q || s1_i.too_long) : s1_i.too_long;

    emit_a = s1_i.valid && s1_i.close && !equal && run_open_q &&
             pass_filter(run_count_q, cfg_i);
    emit_b = s1_i.valid && s1_i.last && pass_filter(new_count, cfg_i);

    // The run that this line closed goes first, then the flushed final run.
    push_o.push_a           = emit_a;
    push_o.rec_a.first_line = run_start_q;
    push_o.rec_a.run_length = run_count_q;
    push_o.rec_a.overflow   = run_ovf_q;
    push_o.rec_a.final_rec  = s1_i.last && !emit_b;
    push_o.push_b           = emit_b;
    push_o.rec_b.first_line = new_start;
    push_o.rec_b.run_length = new_count;
    push_o.rec_b.overflow   = new_ovf;
    push_o.rec_b.final_rec  = 1'b1;

    mismatch_d  = mismatch_q;
    run_count_d = run_count_q;
    run_start_d = run_start_q;
    line_num_d  = line_num_q;
    run_open_d  = run_open_q;
    run_ovf_d   = run_ovf_q;
    if (s1_i.valid) begin
      if (s1_i.last) begin
        mismatch_d  = 1'b0;
        run_count_d = '0;
        run_start_d = '0;
        line_num_d  = '0;
        run_open_d  = 1'b0;
        run_ovf_d   = 1'b0;
      end else if (s1_i.close) begin
        mismatch_d  = 1'b0;
        run_count_d = new_count;
        run_start_d = new_start;
        line_num_d  = sat_inc(line_num_q);
        run_open_d  = 1'b1;
        run_ovf_d   = new_ovf;
      end else begin
        mismatch_d  = mis;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mismatch_q  <= 1'b0;
      run_count_q <= '0;
      run_start_q <= '0;
      line_num_q  <= '0;
      run_open_q  <= 1'b0;
      run_ovf_q   <= 1'b0;
    end else begin
      mismatch_q  <= mismatch_d;
      run_count_q <= run_count_d;
      run_start_q <= run_start_d;
      line_num_q  <= line_num_d;
      run_open_q  <= run_open_d;
      run_ovf_q   <= run_ovf_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/adl_rec_fifo.sv
`default_nettype none

// Record queue: takes up to two records a cycle, delivers one a cycle while ready_i is high.
// The depth is a power of two, so the pointers wrap on their own.
module adl_rec_fifo
  import adl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire push_t               push_i,
  input  wire logic                ready_i,
  output logic                     valid_o,
  output rec_t                     head_o,
  output logic      [FifoCntW-1:0] level_o
);

  rec_t                entry_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;

  logic                pop;
  logic [FifoPtrW-1:0] wr_ptr_b;
  logic [1:0]          npush;

  always_comb begin
    pop      = (cnt_q != '0) && ready_i;
    wr_ptr_b = wr_ptr_q + FifoPtrW'(push_i.push_a);
    npush    = 2'(push_i.push_a) + 2'(push_i.push_b);
  end

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoPtrW'(npush);
      rd_ptr_q <= rd_ptr_q + FifoPtrW'(pop);
      cnt_q    <= cnt_q + FifoCntW'(npush) - FifoCntW'(pop);
    end
  end

  // Record storage.
  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      entry_q[wr_ptr_q] <= push_i.rec_a;
    end
    if (push_i.push_b) begin
      entry_q[wr_ptr_b] <= push_i.rec_b;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign level_o = cnt_q;

endmodule

`default_nettype wire

>>> hdl/adjacent_line_dedup.sv
// Adjacent duplicate line filter.
// Input channel (s_axis): one text byte per transfer, tlast on the final byte
// of a stream. Byte 10 ends a line. Each line is compared with the line before
// it; runs of equal adjacent lines are counted and reported when they close.
// Output channel (m_axis): one record per transfer with the run's first line
// number and length; tuser flags a line that was longer than the buffer and
// tlast marks the last record of a stream. A final byte can release two records.
// Configuration: a write with cfg_we_i sets the register at cfg_idx_i
// (0 duplicates only, 1 singles only, 2 ignore case) from cfg_wdata_i.
// Throughput is one byte per cycle while s_axis_tready is high: each byte does one
// read-first access to the single-port line buffer, and the compare finishes on the
// registered read data. A record is written into the record queue before it leaves.
// A small record queue decouples the sides: input is taken while records wait,
// and s_axis_tready drops only when the queue could not hold two more records
// per byte in flight, so a stalled receiver never loses a record.
// Reset clears all control state and the registers; the line buffer needs no
// clearing pass, since a stored byte is only read after the line before it
// wrote that entry.
`default_nettype none

module adjacent_line_dedup
  import adl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream, tdata: data_byte [7:0]; tlast: end_of_input.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tlast,
  // Output stream, tdata: first_line [31:0], run_length [63:32].
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [63:0] m_axis_tdata,
  // tuser: line_overflow [0]; tlast: final_record.
  output logic      [0:0]  m_axis_tuser,
  output logic             m_axis_tlast,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic        cfg_wdata_i
);

  cfg_t                cfg_q;
  s1_t                 s1;
  push_t               push;
  rec_t                head;
  logic                accept;
  logic                ram_en;
  logic [AddrW-1:0]    ram_addr;
  logic [7:0]          ram_wdata;
  logic [7:0]          ram_rdata;
  logic [FifoCntW-1:0] level;
  logic [FifoCntW:0]   reserve;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgDupOnly:     cfg_q.dup_only     <= cfg_wdata_i;
        CfgSinglesOnly: cfg_q.singles_only <= cfg_wdata_i;
        CfgIgnoreCase:  cfg_q.ignore_case  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Room for two records from the byte in flight and two from a new one.
  always_comb begin
    reserve       = {1'b0, level} + (s1.valid ? (FifoCntW + 1)'(2) : '0);
    s_axis_tready = (reserve <= (FifoCntW + 1)'(FifoDepth - 2));
    accept        = s_axis_tvalid && s_axis_tready;
  end

  adl_position u_position (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .ram_en_o    (ram_en),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .s1_o        (s1)
  );

  adl_line_ram u_line_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  adl_run_tracker u_run_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .s1_i    (s1),
    .rdata_i (ram_rdata),
    .push_o  (push)
  );

  adl_rec_fifo u_rec_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .head_o  (head),
    .level_o (level)
  );

  assign m_axis_tdata = {head.run_length, head.first_line};
  assign m_axis_tuser = head.overflow;
  assign m_axis_tlast = head.final_rec;

endmodule

`default_nettype wire

>>> hdl/adl_checker.sv
`default_nettype none

`include "adjacent_line_dedup_defines.svh"

// Port-level checks for the line dedup block.
module adl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // Everything that one output transfer carries.
  logic [65:0] out_rec;

  assign out_rec = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // A waiting record stays offered until its transfer.
  `ADL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // A waiting record does not change.
  `ADL_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(out_rec))

  // Every reported run holds at least one line.
  `ADL_ASSERT_IMPL(a_len_nonzero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[63:32] != 32'd0)

  // Input is held off only while records are queued for the receiver.
  `ADL_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid)

endmodule

bind adjacent_line_dedup adl_checker u_adl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> tb/tb_adjacent_line_dedup.sv
`default_nettype none

module tb_adjacent_line_dedup
  import adl_pkg::*;
();

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int          DrainCycles = 8;
  localparam int          TailCycles  = 20;
  localparam int          LongHold    = 400;
  localparam int          PhaseCount  = 10;
  localparam int          PhaseItems  = 20;

  // Rows of the directed part: either one byte transfer or one register write.
  typedef enum {RowByte, RowReg} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [7:0] c;
    bit         l;
    bit         typed;
    int         n;
    rec_t       r0;
    rec_t       r1;
    cfg_idx_e   idx;
    bit         v;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // data_byte [7:0]
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // first_line [31:0], run_length [63:32]
  logic [0:0]  m_axis_tuser;   // line_overflow [0]
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic        cfg_wdata_i;

  adjacent_line_dedup u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Run tracker state, a private copy of what the block holds.
  logic [7:0]    line_mem [MaxLine];
  int unsigned   prev_len;
  int unsigned   cur_pos;
  bit            diff_seen;
  logic [CntW-1:0] run_cnt;
  logic [CntW-1:0] run_first;
  logic [CntW-1:0] line_no;
  bit            run_live;
  bit            run_ovf;
  bit            too_long;
  bit            dup_mode;
  bit            single_mode;
  bit            fold_mode;

  rec_t          new_runs[$];
  rec_t          awaited_runs[$];
  stim_row_t     stim[$];

  rec_t          got_run;
  rec_t          want_run;
  int            bad_count;
  int            n_items;
  int            n_streams;
  int            n_runs;
  int            n_long;
  int            long_left;
  int            rx_hold;
  int unsigned   cycles = 0;
  bit            tx_calm;
  bit            rx_calm;
  bit            long_hold_req;
  bit            long_hold_taken;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d records still awaited", cycles,
               awaited_runs.size());
      $display("tb_adjacent_line_dedup NOT OK");
      $finish;
    end
  end

  function automatic logic [7:0] fold_char(logic [7:0] c);
    if (fold_mode && c >= UpA && c <= UpZ) begin
      return c + CaseGap;
    end
    return c;
  endfunction

  function automatic logic [CntW-1:0] bump(logic [CntW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic rec_t mk_run(logic [CntW-1:0] first, logic [CntW-1:0] len, bit ovf,
                                  bit fin);
    rec_t r;
    r.first_line = first;
    r.run_length = len;
    r.overflow   = ovf;
    r.final_rec  = fin;
    return r;
  endfunction

  // A closed run goes out unless one of the filters drops it.
  function automatic void flush_run();
    if (dup_mode && run_cnt == 1) return;
    if (single_mode && run_cnt > 1) return;
    new_runs.push_back(mk_run(run_first, run_cnt, run_ovf, 1'b0));
  endfunction

  function automatic void restart_stream();
    prev_len  = 0;
    cur_pos   = 0;
    diff_seen = 1'b0;
    run_cnt   = '0;
    run_first = '0;
    line_no   = '0;
    run_live  = 1'b0;
    run_ovf   = 1'b0;
    too_long  = 1'b0;
  endfunction

  // Works out the records that one accepted byte releases, into new_runs.
  function automatic void advance_runs(logic [7:0] c, bit l);
    bit same;
    new_runs.delete();
    if (c != NlByte) begin
      if (cur_pos >= MaxLine) begin
        too_long = 1'b1;
      end else begin
        if (cur_pos >= prev_len) begin
          diff_seen = 1'b1;
        end else if (fold_char(line_mem[cur_pos]) != fold_char(c)) begin
          diff_seen = 1'b1;
        end
        line_mem[cur_pos] = c;
        cur_pos++;
      end
    end
    if (c == NlByte || l) begin
      same = run_live && !diff_seen && cur_pos == prev_len;
      if (too_long) n_long++;
      if (same) begin
        run_cnt = bump(run_cnt);
        if (too_long) run_ovf = 1'b1;
      end else begin
        if (run_live) flush_run();
        run_first = line_no;
        run_cnt   = 1;
        run_ovf   = too_long;
        run_live  = 1'b1;
      end
      line_no   = bump(line_no);
      prev_len  = cur_pos;
      cur_pos   = 0;
      diff_seen = 1'b0;
      too_long  = 1'b0;
    end
    if (l) begin
      flush_run();
      if (new_runs.size() > 0) new_runs[new_runs.size()-1].final_rec = 1'b1;
      restart_stream();
    end
  endfunction

  // Mostly no gap, some short ones and a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_char();
    logic [7:0] pool [4];
    logic [7:0] c;
    pool = '{"a", "A", "b", "B"};
    if ($urandom_range(0, 99) < 75) return pool[$urandom_range(0, 3)];
    // Any byte but a newline, so a line stays one line.
    c = 8'($urandom_range(0, 254));
    if (c >= NlByte) c = c + 8'd1;
    return c;
  endfunction

  function automatic stim_row_t byte_row(logic [7:0] c, bit l);
    stim_row_t r;
    r.kind  = RowByte;
    r.c     = c;
    r.l     = l;
    r.typed = 1'b0;
    r.n     = 0;
    r.r0    = '0;
    r.r1    = '0;
    r.idx   = CfgDupOnly;
    r.v     = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t checked_row(logic [7:0] c, bit l, int n, rec_t r0, rec_t r1);
    stim_row_t r;
    r       = byte_row(c, l);
    r.typed = 1'b1;
    r.n     = n;
    r.r0    = r0;
    r.r1    = r1;
    return r;
  endfunction

  function automatic stim_row_t reg_row(cfg_idx_e idx, bit v);
    stim_row_t r;
    r      = byte_row(8'h00, 1'b0);
    r.kind = RowReg;
    r.idx  = idx;
    r.v    = v;
    return r;
  endfunction

  // One input transfer. Typed rows queue their written-out records instead of
  // the tracker's, which still advances its state.
  task automatic send_byte(input logic [7:0] c, input bit l, input bit typed, input int tn,
                           input rec_t t0, input rec_t t1);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_runs(c, l);
    if (typed) begin
      if (tn > 0) awaited_runs.push_back(t0);
      if (tn > 1) awaited_runs.push_back(t1);
    end else begin
      foreach (new_runs[i]) awaited_runs.push_back(new_runs[i]);
    end
    n_items++;
    if (l) n_streams++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every awaited record has come out, then wait out
  // DrainCycles for bytes still in flight that release nothing.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (awaited_runs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input bit v);
    wait_for_drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgDupOnly:     dup_mode    = v;
      CfgSinglesOnly: single_mode = v;
      CfgIgnoreCase:  fold_mode   = v;
      default: ;
    endcase
  endtask

  // One random stream: mostly lines that repeat, vary or restart, with
  // occasional noise streams of arbitrary bytes.
  task automatic send_random_stream(input bit allow_long);
    logic [7:0] txt[$];
    logic [7:0] prev[$];
    logic [7:0] line[$];
    logic [7:0] ch;
    int nl;
    int kind;
    int len;
    bit flip;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 24);
      repeat (len) begin
        txt.push_back(($urandom_range(0, 99) < 30) ? NlByte : 8'($urandom_range(0, 255)));
      end
    end else begin
      nl = $urandom_range(1, 7);
      for (int i = 0; i < nl; i++) begin
        kind = $urandom_range(0, 99);
        line.delete();
        if (allow_long && long_left > 0 && i == nl - 1) begin
          // One line past the buffer size closes the text of this stream.
          long_left--;
          len = $urandom_range(MaxLine + 1, MaxLine + 4);
          repeat (len) line.push_back(rand_char());
        end else if (i > 0 && kind < 45) begin
          // Repeat, sometimes with bit 5 toggled to probe case folding.
          flip = $urandom_range(0, 1);
          foreach (prev[j]) begin
            ch = prev[j];
            if (flip && $urandom_range(0, 99) < 20 && (ch ^ CaseGap) != NlByte) ch = ch ^ CaseGap;
            line.push_back(ch);
          end
        end else if (kind < 55) begin
          // Empty line.
        end else if (i > 0 && kind < 65) begin
          line = prev;
          if (line.size() > 0 && $urandom_range(0, 1)) void'(line.pop_back());
          else line.push_back(rand_char());
        end else begin
          len = $urandom_range(1, 6);
          repeat (len) line.push_back(rand_char());
        end
        foreach (line[j]) txt.push_back(line[j]);
        txt.push_back(NlByte);
        prev = line;
      end
      // Sometimes the final byte is the last text byte rather than a newline.
      if (line.size() > 0 && $urandom_range(0, 1)) void'(txt.pop_back());
    end
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1, 1'b0, 0, '0, '0);
  endtask

  // Receiver: random stalls, calm stretches and one long hold-off.
  initial begin
    m_axis_tready = 1'b0;
    rx_hold = 0;
    long_hold_taken = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        rx_hold = LongHold;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_calm || $urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        rx_hold = pick_gap();
        m_axis_tready <= 1'b0;
      end
    end
  end

  // Each output transfer is compared with the oldest awaited record.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_run = mk_run(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser[0],
                       m_axis_tlast);
      n_runs++;
      if (awaited_runs.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("unexpected record: first=%0d len=%0d ovf=%0b fin=%0b",
                   got_run.first_line, got_run.run_length, got_run.overflow,
                   got_run.final_rec);
        end
      end else begin
        want_run = awaited_runs.pop_front();
        if (got_run !== want_run) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("mismatch: expected first=%0d len=%0d ovf=%0b fin=%0b",
                     want_run.first_line, want_run.run_length, want_run.overflow,
                     want_run.final_rec);
            $display("          got      first=%0d len=%0d ovf=%0b fin=%0b",
                     got_run.first_line, got_run.run_length, got_run.overflow,
                     got_run.final_rec);
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin
    logic [2:0] mode;
    int start;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgDupOnly;
    cfg_wdata_i   = 1'b0;
    bad_count     = 0;
    n_items       = 0;
    n_streams     = 0;
    n_runs        = 0;
    n_long        = 0;
    long_left     = 1;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    long_hold_req = 1'b0;
    dup_mode      = 1'b0;
    single_mode   = 1'b0;
    fold_mode     = 1'b0;
    restart_stream();

    // Directed part. Lines "a","a","b","", then NUL 0xFF with end of input.
    stim.push_back(byte_row("a", 1'b0));
    stim.push_back(byte_row(NlByte, 1'b0));
    stim.push_back(byte_row("a", 1'b0));
    stim.push_back(byte_row(NlByte, 1'b0));
    stim.push_back(byte_row("b", 1'b0));
    stim.push_back(checked_row(NlByte, 1'b0, 1, mk_run(0, 2, 0, 0), '0));
    stim.push_back(checked_row(NlByte, 1'b0, 1, mk_run(2, 1, 0, 0), '0));
    stim.push_back(byte_row(8'h00, 1'b0));
    stim.push_back(checked_row(8'hFF, 1'b1, 2, mk_run(3, 1, 0, 0), mk_run(4, 1, 0, 1)));
    // A lone newline that also ends the stream.
    stim.push_back(checked_row(NlByte, 1'b1, 1, mk_run(0, 1, 0, 1), '0));
    // Case matters by default.
    stim.push_back(byte_row("Z", 1'b0));
    stim.push_back(byte_row(NlByte, 1'b0));
    stim.push_back(byte_row("z", 1'b0));
    stim.push_back(checked_row(NlByte, 1'b1, 2, mk_run(0, 1, 0, 0), mk_run(1, 1, 0, 1)));
    // Same lines under ignore case form one run.
    stim.push_back(reg_row(CfgIgnoreCase, 1'b1));
    stim.push_back(byte_row("Z", 1'b0));
    stim.push_back(byte_row(NlByte, 1'b0));
    stim.push_back(byte_row("z", 1'b0));
    stim.push_back(checked_row(NlByte, 1'b1, 1, mk_run(0, 2, 0, 1), '0));
    // Duplicates only drops a single line, so no record carries the last flag.
    stim.push_back(reg_row(CfgDupOnly, 1'b1));
    stim.push_back(byte_row("p", 1'b0));
    stim.push_back(checked_row(NlByte, 1'b1, 0, '0, '0));
    // Both filters set: nothing is ever reported.
    stim.push_back(reg_row(CfgSinglesOnly, 1'b1));
    stim.push_back(checked_row("q", 1'b1, 0, '0, '0));
    stim.push_back(checked_row("q", 1'b1, 0, '0, '0));

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim[k]) begin
      if (stim[k].kind == RowReg) begin
        set_reg(stim[k].idx, stim[k].v);
      end else begin
        send_byte(stim[k].c, stim[k].l, stim[k].typed, stim[k].n, stim[k].r0, stim[k].r1);
      end
    end

    // Random phases: every register setting, then a couple of random ones.
    for (int p = 0; p < PhaseCount; p++) begin
      mode = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
      set_reg(CfgDupOnly, mode[0]);
      set_reg(CfgSinglesOnly, mode[1]);
      set_reg(CfgIgnoreCase, mode[2]);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        tx_calm = 1'b1;
        long_hold_req = 1'b1;
      end
      start = n_items;
      while (n_items - start < PhaseItems) begin
        send_random_stream(p < 2);
        // Halfway through one phase the sender waits for the output to drain.
        if (p == 4 && n_items - start >= PhaseItems / 2 && n_items - start < PhaseItems / 2 + 20)
          wait_for_drain();
      end
    end

    wait_for_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (awaited_runs.size() != 0) bad_count++;

    $display("run covered %0d bytes in %0d streams, %0d records checked", n_items, n_streams,
             n_runs);
    $display("lines longer than the buffer: %0d, failures: %0d", n_long, bad_count);
    if (bad_count == 0) begin
      $display("tb_adjacent_line_dedup OK");
    end else begin
      $display("tb_adjacent_line_dedup NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/adl_pkg.sv
hdl/adl_line_ram.sv
hdl/adl_position.sv
hdl/adl_run_tracker.sv
hdl/adl_rec_fifo.sv
hdl/adjacent_line_dedup.sv
hdl/adl_checker.sv
tb/tb_adjacent_line_dedup.sv
